// ----- rtl/core/clnws_pkg.sv -----
// Shared types and constants for the character display nibble write sequencer.
`timescale 1ns / 1ps
package clnws_pkg;

  // Sequencer phases; each phase other than idle is one timed segment.
  typedef enum logic [2:0] {
    PH_ARM,
    PH_POWER,
    PH_ENHI,
    PH_ENLO,
    PH_POST,
    PH_EXTRA,
    PH_IDLE
  } phase_t;

  // Request opcodes.
  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_CMD   = 3'd1;
  localparam logic [2:0] OP_DATA  = 3'd2;
  localparam logic [2:0] OP_POS   = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  // Kind of the byte in flight.
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_CMD   = 3'd1;
  localparam logic [2:0] KIND_DATA  = 3'd2;
  localparam logic [2:0] KIND_POS   = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE_HIGH = 3'd0;
  localparam logic [2:0] REG_ENABLE_GAP  = 3'd1;
  localparam logic [2:0] REG_BYTE_WAIT   = 3'd2;
  localparam logic [2:0] REG_POWER_WAIT  = 3'd3;
  localparam logic [2:0] REG_INIT_GAP    = 3'd4;
  localparam logic [2:0] REG_CLEAR_EXTRA = 3'd5;
  localparam logic [2:0] REG_CHAR_EXTRA  = 3'd6;

  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned IDX_WIDTH = 3;

  // Display command bytes and init nibbles.
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic       CMD_POS_FLAG  = 1'b1;
  localparam logic [6:0] ROW1_BASE     = 7'h40;
  localparam logic [3:0] NIB_INIT      = 4'h3;
  localparam logic [3:0] NIB_4BIT      = 4'h2;

  // Init step bounds: nibble pulses below INIT_BYTES, init bytes below INIT_DONE.
  localparam logic [3:0] INIT_LAST_NIB = 4'd3;
  localparam logic [3:0] INIT_BYTES    = 4'd4;
  localparam logic [3:0] INIT_DONE     = 4'd8;

  typedef struct packed {
    logic [15:0] enable_high;
    logic [15:0] enable_gap;
    logic [15:0] byte_wait;
    logic [15:0] power_wait;
    logic [15:0] init_gap;
    logic [15:0] clear_extra;
    logic [15:0] char_extra;
  } cfg_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  init_step;
    logic [15:0] wait_count;
    logic [7:0]  pending_byte;
    logic [2:0]  pending_kind;
    logic        nibble_phase;
    logic        rs_level;
    logic        en_level;
    logic [3:0]  nibble_level;
  } seq_state_t;

  typedef struct packed {
    logic done;     // word result is final this cycle
    logic taken;    // request taken this cycle
    logic checked;  // request check was made this cycle
  } step_ctl_t;

endpackage

// ----- rtl/core/clnws_cfg.sv -----
// Timing configuration registers of the sequencer.
`timescale 1ns / 1ps
module clnws_cfg
  import clnws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_high <= 16'd1;
      cfg.enable_gap  <= 16'd50;
      cfg.byte_wait   <= 16'd2000;
      cfg.power_wait  <= 16'd20000;
      cfg.init_gap    <= 16'd5000;
      cfg.clear_extra <= 16'd2000;
      cfg.char_extra  <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE_HIGH: cfg.enable_high <= cfg_data;
        REG_ENABLE_GAP:  cfg.enable_gap  <= cfg_data;
        REG_BYTE_WAIT:   cfg.byte_wait   <= cfg_data;
        REG_POWER_WAIT:  cfg.power_wait  <= cfg_data;
        REG_INIT_GAP:    cfg.init_gap    <= cfg_data;
        REG_CLEAR_EXTRA: cfg.clear_extra <= cfg_data;
        REG_CHAR_EXTRA:  cfg.char_extra  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/clnws_step.sv -----
// Next-state logic: one segment advance, request take and byte start per cycle.
`timescale 1ns / 1ps
module clnws_step
  import clnws_pkg::*;
(
  input  seq_state_t cur,
  input  cfg_t       cfg,
  input  logic       req_done,
  input  logic [2:0] opcode,
  input  logic [7:0] byte_value,
  input  logic [5:0] column,
  input  logic       row,
  output seq_state_t nxt,
  output step_ctl_t  ctl
);

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_FUNC_SET;
      2'd1:    b = CMD_DISP_ON;
      2'd2:    b = CMD_ENTRY;
      default: b = CMD_CLEAR;
    endcase
    return b;
  endfunction

  function automatic seq_state_t begin_byte(input seq_state_t s, input logic [7:0] b,
                                            input logic [2:0] k, input cfg_t c);
    seq_state_t r;
    r              = s;
    r.pending_byte = b;
    r.pending_kind = k;
    r.rs_level     = (k == KIND_DATA);
    r.nibble_phase = 1'b0;
    r.nibble_level = b[7:4];
    r.en_level     = 1'b1;
    r.phase        = PH_ENHI;
    r.wait_count   = c.enable_high;
    return r;
  endfunction

  function automatic seq_state_t finish_byte(input seq_state_t s, input cfg_t c);
    seq_state_t r;
    logic [3:0] step_n;
    r      = s;
    step_n = s.init_step + 4'd1;
    if (s.init_step >= INIT_BYTES && s.init_step < INIT_DONE && step_n < INIT_DONE) begin
      r.init_step = step_n;
      // step_n - 4 keeps its low two bits
      r = begin_byte(r, init_byte(step_n[1:0]),
                     (step_n[1:0] == 2'd3) ? KIND_CLEAR : KIND_CMD, c);
    end else begin
      if (s.init_step >= INIT_BYTES && s.init_step < INIT_DONE) begin
        r.init_step = step_n;
      end
      r.phase      = PH_IDLE;
      r.wait_count = 16'd0;
    end
    return r;
  endfunction

  function automatic seq_state_t advance(input seq_state_t s, input cfg_t c);
    seq_state_t r;
    logic [3:0] step_n;
    r      = s;
    step_n = s.init_step + 4'd1;
    unique case (s.phase)
      PH_ARM: begin
        r.phase      = PH_POWER;
        r.wait_count = c.power_wait;
      end
      PH_POWER: begin
        r.init_step    = 4'd0;
        r.rs_level     = 1'b0;
        r.nibble_level = NIB_INIT;
        r.en_level     = 1'b1;
        r.phase        = PH_ENHI;
        r.wait_count   = c.enable_high;
      end
      PH_ENHI: begin
        r.en_level   = 1'b0;
        r.phase      = PH_ENLO;
        r.wait_count = c.enable_gap;
      end
      PH_ENLO: begin
        if (s.init_step < INIT_BYTES) begin
          r.phase      = PH_POST;
          r.wait_count = c.init_gap;
        end else if (!s.nibble_phase) begin
          r.nibble_phase = 1'b1;
          r.nibble_level = s.pending_byte[3:0];
          r.en_level     = 1'b1;
          r.phase        = PH_ENHI;
          r.wait_count   = c.enable_high;
        end else begin
          r.phase      = PH_POST;
          r.wait_count = c.byte_wait;
        end
      end
      PH_POST: begin
        if (s.init_step < INIT_BYTES) begin
          r.init_step = step_n;
          if (step_n < INIT_BYTES) begin
            r.nibble_level = (step_n == INIT_LAST_NIB) ? NIB_4BIT : NIB_INIT;
            r.en_level     = 1'b1;
            r.phase        = PH_ENHI;
            r.wait_count   = c.enable_high;
          end else begin
            r = begin_byte(r, CMD_FUNC_SET, KIND_CMD, c);
          end
        end else if (s.pending_kind == KIND_CLEAR) begin
          r.phase      = PH_EXTRA;
          r.wait_count = c.clear_extra;
        end else if (s.pending_kind == KIND_DATA) begin
          r.phase      = PH_EXTRA;
          r.wait_count = c.char_extra;
        end else begin
          r = finish_byte(s, c);
        end
      end
      PH_EXTRA: r = finish_byte(s, c);
      default: begin
        r.phase      = PH_IDLE;
        r.wait_count = 16'd0;
      end
    endcase
    return r;
  endfunction

  seq_state_t s1;
  seq_state_t s2;
  logic       need0;
  logic       settled1;
  logic       is_req;
  logic       take;
  logic [7:0] req_byte;
  logic [2:0] req_kind;
  logic [6:0] pos_addr;

  assign need0    = (cur.phase != PH_IDLE) && (cur.wait_count == 16'd0);
  assign s1       = need0 ? advance(cur, cfg) : cur;
  assign settled1 = (s1.phase == PH_IDLE) || (s1.wait_count != 16'd0);

  // Row base plus column, wrapping within 7 bits.
  assign pos_addr = (row ? ROW1_BASE : 7'd0) + {1'b0, column};

  always_comb begin
    is_req   = 1'b1;
    req_byte = byte_value;
    req_kind = KIND_CMD;
    unique case (opcode)
      OP_CMD: begin
        req_byte = byte_value;
        req_kind = KIND_CMD;
      end
      OP_DATA: begin
        req_byte = byte_value;
        req_kind = KIND_DATA;
      end
      OP_POS: begin
        req_byte = {CMD_POS_FLAG, pos_addr};
        req_kind = KIND_POS;
      end
      OP_CLEAR: begin
        req_byte = CMD_CLEAR;
        req_kind = KIND_CLEAR;
      end
      default: begin
        is_req   = 1'b0;
        req_kind = KIND_NONE;
      end
    endcase
  end

  assign take = settled1 && !req_done && (s1.phase == PH_IDLE) && is_req;
  assign s2   = take ? begin_byte(s1, req_byte, req_kind, cfg) : s1;
  assign nxt  = s2;

  assign ctl.taken   = take;
  assign ctl.checked = settled1;
  assign ctl.done    = settled1 && ((s2.phase == PH_IDLE) || (s2.wait_count != 16'd0));

endmodule

// ----- rtl/core/char_lcd_nibble_write_sequencer_unit.sv -----
// Top level of the character display nibble write sequencer.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tick word: opcode, byte_value, column, row
//  m_*     | out | m_tvalid/m_tready  | pin word: tuser RS, tdata RW/EN/D/busy/acc
//  cfg_*   | in  | cfg_we             | timing register index and value
//
// A tick word is registered on input and resolved from that register; one word per
// cycle is sustained while segments are at least one tick long and the output is not
// stalled. A run of zero-length segments holds the word until each is skipped, one at
// a time by the single advance unit in clnws_step. Reset clears the sequencer to the
// power-up arm state and loads the default timings. A stalled output holds the sequencer.
`timescale 1ns / 1ps
module char_lcd_nibble_write_sequencer_unit
  import clnws_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [23:0]          s_tdata,   // opcode[2:0], byte_value[10:3], column[16:11], row[17]
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // read_write[0], enable_pin[1], data_nibble[5:2],
                                          // busy_res[6], accepted[7]
  output logic                 m_tuser,   // reg_select[0]
  input  logic                 cfg_we,
  input  logic [IDX_WIDTH-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data
);

  cfg_t       cfg;
  seq_state_t state;
  seq_state_t state_next;
  seq_state_t step_nxt;
  step_ctl_t  ctl;

  logic       in_valid;
  logic [2:0] in_opcode;
  logic [7:0] in_byte;
  logic [5:0] in_column;
  logic       in_row;
  logic       req_done;
  logic       acc_hold;
  logic       out_free;
  logic       pop;
  logic       work;

  clnws_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clnws_step u_step (
    .cur        (state),
    .cfg        (cfg),
    .req_done   (req_done),
    .opcode     (in_opcode),
    .byte_value (in_byte),
    .column     (in_column),
    .row        (in_row),
    .nxt        (step_nxt),
    .ctl        (ctl)
  );

  assign out_free = !m_tvalid || m_tready;
  assign pop      = in_valid && ctl.done && out_free;
  assign work     = in_valid && (!ctl.done || out_free);
  assign s_tready = !in_valid || pop;

  // Count down the current segment once the word is delivered.
  always_comb begin
    state_next = step_nxt;
    if (ctl.done && (step_nxt.phase != PH_IDLE) && (step_nxt.wait_count != 16'd0)) begin
      state_next.wait_count = step_nxt.wait_count - 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (pop) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_opcode <= s_tdata[2:0];
      in_byte   <= s_tdata[10:3];
      in_column <= s_tdata[16:11];
      in_row    <= s_tdata[17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase        <= PH_ARM;
      state.init_step    <= 4'd0;
      state.wait_count   <= 16'd0;
      state.pending_byte <= 8'd0;
      state.pending_kind <= KIND_NONE;
      state.nibble_phase <= 1'b0;
      state.rs_level     <= 1'b0;
      state.en_level     <= 1'b0;
      state.nibble_level <= 4'd0;
      req_done           <= 1'b0;
      acc_hold           <= 1'b0;
    end else if (work) begin
      state <= state_next;
      if (pop) begin
        req_done <= 1'b0;
        acc_hold <= 1'b0;
      end else begin
        // hold the request outcome across skipped segments
        if (ctl.checked) req_done <= 1'b1;
        if (ctl.taken)   acc_hold <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tuser    <= step_nxt.rs_level;
      m_tdata[0] <= 1'b0;
      m_tdata[1] <= step_nxt.en_level;
      m_tdata[5:2] <= step_nxt.nibble_level;
      m_tdata[6] <= (step_nxt.phase != PH_IDLE);
      m_tdata[7] <= ctl.taken || acc_hold;
    end
  end

endmodule
